// ===== rtl/core/aarm_pkg.sv =====
// Shared types, widths and tables for the axis-angle rotation matrix core.
package aarm_pkg;

    localparam int IO_W             = 16;
    localparam int ANGLE_W          = 16;
    localparam int RESID_W          = 14;
    localparam int CORE_FRAC        = 30;
    localparam int XY_W             = 32;
    localparam int Z_W              = 34;
    localparam int Z_ALIGN          = 16;
    localparam int T_W              = 18;
    localparam int MAX_STEPS        = 32;
    localparam int FRAC_BITS_DEF    = 14;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [XY_W-1:0] CORDIC_GAIN = 32'sd652032874;

    localparam logic signed [IO_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [IO_W-1:0] OUT_MIN = 16'sh8000;

    // arctan(2^-i) in units of 2^-32 turn
    localparam logic [31:0] ATAN_TURNS [MAX_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef enum logic [1:0] {
        QUAD_I   = 2'd0,
        QUAD_II  = 2'd1,
        QUAD_III = 2'd2,
        QUAD_IV  = 2'd3
    } quad_t;

    typedef struct packed {
        logic signed [IO_W-1:0] x;
        logic signed [IO_W-1:0] y;
        logic signed [IO_W-1:0] z;
    } axis_t;

endpackage

// ===== rtl/core/aarm_cordic.sv =====
// Pipelined rotation-mode CORDIC: one iteration per stage, quadrant fold at the end.
module aarm_cordic
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF,
    localparam int CS_W        = FRAC_BITS + 2
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  axis_t                  in_axis,
    input  logic [ANGLE_W-1:0]     in_angle,
    output logic                   out_valid,
    input  logic                   out_ready,
    output axis_t                  out_axis,
    output logic signed [CS_W-1:0] out_c,
    output logic signed [CS_W-1:0] out_s
);

    localparam int NV    = CORDIC_STEPS + 2;
    localparam int SHIFT = CORE_FRAC - FRAC_BITS;

    logic [NV-1:0] valid_reg;
    logic [NV-1:0] valid_next;
    logic [NV:0]   ld;

    logic signed [XY_W-1:0] x_reg [0:CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [0:CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [0:CORDIC_STEPS];
    quad_t                  quad_reg [0:CORDIC_STEPS];
    axis_t                  axis_reg [0:NV-1];
    logic signed [CS_W-1:0] c_reg;
    logic signed [CS_W-1:0] s_reg;

    logic signed [XY_W-1:0] cq;
    logic signed [XY_W-1:0] sq;

    // a stage loads when it is empty or its successor loads
    assign ld[NV] = out_ready;
    for (genvar k = 0; k < NV; k++) begin : g_ld
        assign ld[k] = !valid_reg[k] || ld[k+1];
    end

    assign in_ready   = ld[0];
    assign valid_next = (ld[NV-1:0] & {valid_reg[NV-2:0], in_valid})
                      | (~ld[NV-1:0] & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            x_reg[0]    <= CORDIC_GAIN;
            y_reg[0]    <= '0;
            z_reg[0]    <= Z_W'({in_angle[RESID_W-1:0], {Z_ALIGN{1'b0}}});
            quad_reg[0] <= quad_t'(in_angle[ANGLE_W-1:RESID_W]);
            axis_reg[0] <= in_axis;
        end
    end

    for (genvar k = 1; k <= CORDIC_STEPS; k++) begin : g_iter
        logic signed [Z_W-1:0] atan_k;
        assign atan_k = Z_W'(ATAN_TURNS[k-1]);

        always_ff @(posedge aclk) begin
            if (ld[k]) begin
                if (!z_reg[k-1][Z_W-1]) begin
                    x_reg[k] <= x_reg[k-1] - (y_reg[k-1] >>> (k-1));
                    y_reg[k] <= y_reg[k-1] + (x_reg[k-1] >>> (k-1));
                    z_reg[k] <= z_reg[k-1] - atan_k;
                end else begin
                    x_reg[k] <= x_reg[k-1] + (y_reg[k-1] >>> (k-1));
                    y_reg[k] <= y_reg[k-1] - (x_reg[k-1] >>> (k-1));
                    z_reg[k] <= z_reg[k-1] + atan_k;
                end
                quad_reg[k] <= quad_reg[k-1];
                axis_reg[k] <= axis_reg[k-1];
            end
        end
    end

    always_comb begin
        unique case (quad_reg[CORDIC_STEPS])
            QUAD_I: begin
                cq = x_reg[CORDIC_STEPS];
                sq = y_reg[CORDIC_STEPS];
            end
            QUAD_II: begin
                cq = -y_reg[CORDIC_STEPS];
                sq = x_reg[CORDIC_STEPS];
            end
            QUAD_III: begin
                cq = -x_reg[CORDIC_STEPS];
                sq = -y_reg[CORDIC_STEPS];
            end
            QUAD_IV: begin
                cq = y_reg[CORDIC_STEPS];
                sq = -x_reg[CORDIC_STEPS];
            end
            default: begin
                cq = x_reg[CORDIC_STEPS];
                sq = y_reg[CORDIC_STEPS];
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ld[NV-1]) begin
            c_reg          <= CS_W'(cq >>> SHIFT);
            s_reg          <= CS_W'(sq >>> SHIFT);
            axis_reg[NV-1] <= axis_reg[CORDIC_STEPS];
        end
    end

    assign out_valid = valid_reg[NV-1];
    assign out_axis  = axis_reg[NV-1];
    assign out_c     = c_reg;
    assign out_s     = s_reg;

endmodule

// ===== rtl/core/aarm_product.sv =====
// Two multiplier stages: (1-c)*u_i and s*u_k, then the outer products t_i*u_j.
module aarm_product
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CS_W     = FRAC_BITS + 2,
    localparam int Q_W      = T_W + IO_W - FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  axis_t                  in_axis,
    input  logic signed [CS_W-1:0] in_c,
    input  logic signed [CS_W-1:0] in_s,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [Q_W-1:0]  out_q [9],
    output logic signed [T_W-1:0]  out_sv [3],
    output logic signed [CS_W-1:0] out_c
);

    localparam int OMC_W = FRAC_BITS + 3;

    logic [1:0] valid_reg;
    logic [1:0] valid_next;
    logic [2:0] ld;

    logic signed [IO_W-1:0]  u_in [3];
    logic signed [IO_W-1:0]  u1 [3];
    logic signed [OMC_W-1:0] one_q;
    logic signed [OMC_W-1:0] omc;

    logic signed [T_W-1:0]  t_reg [3];
    logic signed [T_W-1:0]  sv1_reg [3];
    logic signed [CS_W-1:0] c1_reg;
    axis_t                  axis1_reg;

    logic signed [Q_W-1:0]  q_reg [9];
    logic signed [T_W-1:0]  sv2_reg [3];
    logic signed [CS_W-1:0] c2_reg;

    assign ld[2] = out_ready;
    assign ld[1] = !valid_reg[1] || ld[2];
    assign ld[0] = !valid_reg[0] || ld[1];

    assign in_ready   = ld[0];
    assign valid_next = (ld[1:0] & {valid_reg[0], in_valid}) | (~ld[1:0] & valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign u_in[0] = in_axis.x;
    assign u_in[1] = in_axis.y;
    assign u_in[2] = in_axis.z;
    assign u1[0]   = axis1_reg.x;
    assign u1[1]   = axis1_reg.y;
    assign u1[2]   = axis1_reg.z;

    assign one_q = OMC_W'(1) << FRAC_BITS;
    assign omc   = one_q - OMC_W'(in_c);

    for (genvar i = 0; i < 3; i++) begin : g_first
        logic signed [OMC_W+IO_W-1:0] pt;
        logic signed [CS_W+IO_W-1:0]  ps;

        assign pt = (OMC_W+IO_W)'(omc) * (OMC_W+IO_W)'(u_in[i]);
        assign ps = (CS_W+IO_W)'(in_s) * (CS_W+IO_W)'(u_in[i]);

        always_ff @(posedge aclk) begin
            if (ld[0]) begin
                t_reg[i]   <= T_W'(pt >>> FRAC_BITS);
                sv1_reg[i] <= T_W'(ps >>> FRAC_BITS);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            c1_reg    <= in_c;
            axis1_reg <= in_axis;
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic signed [T_W+IO_W-1:0] pq;

            assign pq = (T_W+IO_W)'(t_reg[i]) * (T_W+IO_W)'(u1[j]);

            always_ff @(posedge aclk) begin
                if (ld[1]) begin
                    q_reg[i*3+j] <= Q_W'(pq >>> FRAC_BITS);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld[1]) begin
            sv2_reg <= sv1_reg;
            c2_reg  <= c1_reg;
        end
    end

    assign out_valid = valid_reg[1];
    assign out_q     = q_reg;
    assign out_sv    = sv2_reg;
    assign out_c     = c2_reg;

endmodule

// ===== rtl/core/aarm_sum.sv =====
// Final stage: add diagonal and cross terms, saturate, hold in the output register.
module aarm_sum
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int CS_W     = FRAC_BITS + 2,
    localparam int Q_W      = T_W + IO_W - FRAC_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic signed [Q_W-1:0]  in_q [9],
    input  logic signed [T_W-1:0]  in_sv [3],
    input  logic signed [CS_W-1:0] in_c,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [IO_W-1:0] out_m [9]
);

    localparam int W1    = (Q_W > CS_W) ? Q_W : CS_W;
    localparam int SUM_W = ((W1 > T_W) ? W1 : T_W) + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(OUT_MAX);
    localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(OUT_MIN);

    logic                   valid_reg;
    logic signed [IO_W-1:0] m_reg [9];
    logic signed [IO_W-1:0] sat [9];

    assign in_ready = !valid_reg || out_ready;

    for (genvar i = 0; i < 3; i++) begin : g_row
        for (genvar j = 0; j < 3; j++) begin : g_col
            logic signed [SUM_W-1:0] acc;

            if (j == i) begin : g_diag
                assign acc = SUM_W'(in_q[i*3+j]) + SUM_W'(in_c);
            end else if (j == (i + 1) % 3) begin : g_neg
                assign acc = SUM_W'(in_q[i*3+j]) - SUM_W'(in_sv[(i+2)%3]);
            end else begin : g_pos
                assign acc = SUM_W'(in_q[i*3+j]) + SUM_W'(in_sv[(i+1)%3]);
            end

            assign sat[i*3+j] = (acc > SAT_HI) ? OUT_MAX :
                                (acc < SAT_LO) ? OUT_MIN : acc[IO_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            m_reg <= sat;
        end
    end

    assign out_valid = valid_reg;
    assign out_m     = m_reg;

endmodule

// ===== rtl/core/axis_angle_rotation_matrix_core.sv =====
// Axis-angle to 3x3 rotation matrix core (Rodrigues formula), fixed point.
// Throughput: one word per cycle while m_ready is high; set by the one-iteration-per-stage CORDIC and the
// fully pipelined multiplier stages, each stage stalls only when its successor is full.
// Reset: aresetn is synchronous, active low, and clears every stage valid bit;
// payload registers are not reset.
module axis_angle_rotation_matrix_core
    import aarm_pkg::*;
#(
    parameter int FRAC_BITS    = FRAC_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,

    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic signed [IO_W-1:0]    s_axis_x,
    input  logic signed [IO_W-1:0]    s_axis_y,
    input  logic signed [IO_W-1:0]    s_axis_z,
    input  logic [ANGLE_W-1:0]        s_angle,

    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [IO_W-1:0]    m_m00,
    output logic signed [IO_W-1:0]    m_m01,
    output logic signed [IO_W-1:0]    m_m02,
    output logic signed [IO_W-1:0]    m_m10,
    output logic signed [IO_W-1:0]    m_m11,
    output logic signed [IO_W-1:0]    m_m12,
    output logic signed [IO_W-1:0]    m_m20,
    output logic signed [IO_W-1:0]    m_m21,
    output logic signed [IO_W-1:0]    m_m22
);

    localparam int CS_W  = FRAC_BITS + 2;
    localparam int Q_W   = T_W + IO_W - FRAC_BITS;
    // |cos| and |sin| stay within one unit plus a small CORDIC residue
    localparam logic signed [CS_W-1:0] C_LIM =
        CS_W'((1 << FRAC_BITS) + (1 << (FRAC_BITS - 7)));

    axis_t in_axis;

    // CORDIC -> multiplier stages
    logic                   cs_valid;
    logic                   cs_ready;
    axis_t                  cs_axis;
    logic signed [CS_W-1:0] cs_c;
    logic signed [CS_W-1:0] cs_s;

    // multiplier stages -> sum/saturate output stage
    logic                   pr_valid;
    logic                   pr_ready;
    logic signed [Q_W-1:0]  pr_q [9];
    logic signed [T_W-1:0]  pr_sv [3];
    logic signed [CS_W-1:0] pr_c;

    logic signed [IO_W-1:0] m_out [9];

    assign in_axis.x = s_axis_x;
    assign in_axis.y = s_axis_y;
    assign in_axis.z = s_axis_z;

    // Sine and cosine of the binary angle; the axis rides along with each word.
    aarm_cordic #(
        .FRAC_BITS   (FRAC_BITS),
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_axis  (in_axis),
        .in_angle (s_angle),
        .out_valid(cs_valid),
        .out_ready(cs_ready),
        .out_axis (cs_axis),
        .out_c    (cs_c),
        .out_s    (cs_s)
    );

    // (1-c)*u_i, s*u_k, then the nine outer products, each truncated after forming.
    aarm_product #(
        .FRAC_BITS(FRAC_BITS)
    ) u_product (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (cs_valid),
        .in_ready (cs_ready),
        .in_axis  (cs_axis),
        .in_c     (cs_c),
        .in_s     (cs_s),
        .out_valid(pr_valid),
        .out_ready(pr_ready),
        .out_q    (pr_q),
        .out_sv   (pr_sv),
        .out_c    (pr_c)
    );

    // Add c on the diagonal and the cross-product terms, saturate, register.
    aarm_sum #(
        .FRAC_BITS(FRAC_BITS)
    ) u_sum (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (pr_valid),
        .in_ready (pr_ready),
        .in_q     (pr_q),
        .in_sv    (pr_sv),
        .in_c     (pr_c),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_m    (m_out)
    );

    // Row-major output order.
    assign m_m00 = m_out[0];
    assign m_m01 = m_out[1];
    assign m_m02 = m_out[2];
    assign m_m10 = m_out[3];
    assign m_m11 = m_out[4];
    assign m_m12 = m_out[5];
    assign m_m20 = m_out[6];
    assign m_m21 = m_out[7];
    assign m_m22 = m_out[8];

`ifndef SYNTHESIS
    // Input stalls only when every stage is full and the output word is blocked.
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while pipeline still had room");

    a_cos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cs_valid |-> ((cs_c <= C_LIM) && (cs_c >= -C_LIM)))
        else $error("CORDIC cosine out of range");

    a_sin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cs_valid |-> ((cs_s <= C_LIM) && (cs_s >= -C_LIM)))
        else $error("CORDIC sine out of range");
`endif

endmodule
